// File: sv/ptk_pkg.sv
// ptk_pkg: shared types and constants for the point to tile key block
// no dependencies
`default_nettype none
package ptk_pkg;

  localparam int IDX_W     = 26;              // bits of one row or col index
  localparam int LVL_W     = 5;               // stored level bits
  localparam int MAX_LVL   = 31;
  localparam int MAG_W     = 49;              // magnitude of a coordinate offset
  localparam int DVD_W     = MAG_W + MAX_LVL; // shifted dividend width
  localparam int SPAN_W    = 47;
  localparam int COORD_W   = 48;
  localparam int KEY_W     = 57;
  localparam int LVL_SHIFT = 52;
  localparam int DIV_STEPS = DVD_W;           // one quotient bit per stage

  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_SPAN_X   = 2'd2,
    REG_SPAN_Y   = 2'd3
  } reg_idx_t;

  // classified item between front and back
  typedef struct packed {
    logic [DVD_W-1:0] dvd_x;
    logic             neg_x;
    logic [DVD_W-1:0] dvd_y;
    logic             neg_y;
    logic [LVL_W-1:0] level;
    logic             level_ok;
  } work_t;

  // one divider lane in flight
  typedef struct packed {
    logic [DVD_W-1:0]  dvd;
    logic [SPAN_W-1:0] rem;
    logic [IDX_W-1:0]  quo;
    logic              over;
  } lane_t;

  typedef struct packed {
    lane_t            lx;
    lane_t            ly;
    logic             neg_x;
    logic             neg_y;
    logic [LVL_W-1:0] level;
    logic             level_ok;
  } stage_t;

  typedef struct packed {
    logic [KEY_W-1:0] tile_key;
    logic             key_valid;
    logic [IDX_W-1:0] tile_row;
    logic [IDX_W-1:0] tile_col;
  } result_t;

  // one restoring division step
  function automatic lane_t div_step(input lane_t a, input logic [SPAN_W-1:0] span);
    lane_t            r;
    logic [SPAN_W:0]  rem2;
    logic             ge;
    rem2   = {a.rem, a.dvd[DVD_W-1]};
    ge     = (rem2 >= {1'b0, span});
    r.dvd  = {a.dvd[DVD_W-2:0], 1'b0};
    r.rem  = ge ? SPAN_W'(rem2 - {1'b0, span}) : rem2[SPAN_W-1:0];
    r.quo  = {a.quo[IDX_W-2:0], ge};
    r.over = a.over | a.quo[IDX_W-1];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/ptk_fifo.sv
// ptk_fifo: small flop based queue with registered storage
// no dependencies
`default_nettype none
module ptk_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign rdata = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr[AW-1:0]] <= wdata;
    end
  end
endmodule
`default_nettype wire

// File: sv/ptk_front.sv
// ptk_front: accepts points, forms offsets, magnitudes and shifted dividends
// depends on ptk_pkg
`default_nettype none
module ptk_front import ptk_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic signed [COORD_W-1:0] point_x,
  input  wire logic signed [COORD_W-1:0] point_y,
  input  wire logic [5:0]                pyramid_level,
  input  wire logic signed [COORD_W-1:0] origin_x,
  input  wire logic signed [COORD_W-1:0] origin_y,
  output logic                           q_push,
  output work_t                          q_item,
  input  wire logic                      q_full
);
  logic             r_valid;
  logic [MAG_W-1:0] r_dx;
  logic [MAG_W-1:0] r_dy;
  logic [5:0]       r_lvl;
  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;

  assign q_push = r_valid && !q_full;
  assign full   = r_valid && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (push && !full) begin
      r_valid <= 1'b1;
    end else if (q_push) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      r_dx  <= MAG_W'({point_x[COORD_W-1], point_x} - {origin_x[COORD_W-1], origin_x});
      r_dy  <= MAG_W'({origin_y[COORD_W-1], origin_y} - {point_y[COORD_W-1], point_y});
      r_lvl <= pyramid_level;
    end
  end

  always_comb begin
    mag_x = r_dx[MAG_W-1] ? MAG_W'(-r_dx) : r_dx;
    mag_y = r_dy[MAG_W-1] ? MAG_W'(-r_dy) : r_dy;
    q_item.neg_x    = r_dx[MAG_W-1];
    q_item.neg_y    = r_dy[MAG_W-1];
    q_item.dvd_x    = {{MAX_LVL{1'b0}}, mag_x} << r_lvl[LVL_W-1:0];
    q_item.dvd_y    = {{MAX_LVL{1'b0}}, mag_y} << r_lvl[LVL_W-1:0];
    q_item.level    = r_lvl[LVL_W-1:0];
    q_item.level_ok = !r_lvl[5];
  end
endmodule
`default_nettype wire

// File: sv/ptk_back.sv
// ptk_back: pipelined restoring dividers for col and row, then key packing
// depends on ptk_pkg
`default_nettype none
module ptk_back import ptk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire work_t             q_item,
  output logic                   q_pop,
  input  wire logic [SPAN_W-1:0] span_x,
  input  wire logic [SPAN_W-1:0] span_y,
  output logic                   r_push,
  output result_t                r_item,
  input  wire logic              r_full
);
  logic   pl_v [DIV_STEPS];
  stage_t pl   [DIV_STEPS];
  stage_t head;
  stage_t last;
  logic   advance;
  logic   ok;
  logic [2*IDX_W-1:0] ilv;

  // one divider stage for both lanes, side fields ride along
  function automatic stage_t stage_step(input stage_t a, input logic [SPAN_W-1:0] sx,
                                        input logic [SPAN_W-1:0] sy);
    stage_t r;
    r    = a;
    r.lx = div_step(a.lx, sx);
    r.ly = div_step(a.ly, sy);
    return r;
  endfunction

  assign advance = !(pl_v[DIV_STEPS-1] && r_full);
  assign q_pop   = advance && !q_empty;
  assign r_push  = advance && pl_v[DIV_STEPS-1];

  always_comb begin
    head.lx       = '{dvd: q_item.dvd_x, rem: '0, quo: '0, over: 1'b0};
    head.ly       = '{dvd: q_item.dvd_y, rem: '0, quo: '0, over: 1'b0};
    head.neg_x    = q_item.neg_x;
    head.neg_y    = q_item.neg_y;
    head.level    = q_item.level;
    head.level_ok = q_item.level_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STEPS; s++) pl_v[s] <= 1'b0;
    end else if (advance) begin
      pl_v[0] <= !q_empty;
      for (int s = 1; s < DIV_STEPS; s++) pl_v[s] <= pl_v[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pl[0] <= stage_step(head, span_x, span_y);
      for (int s = 1; s < DIV_STEPS; s++) begin
        pl[s] <= stage_step(pl[s-1], span_x, span_y);
      end
    end
  end

  assign last = pl[DIV_STEPS-1];

  always_comb begin
    ok = last.level_ok
      && !last.lx.over && !(last.neg_x && (last.lx.quo != '0))
      && !last.ly.over && !(last.neg_y && (last.ly.quo != '0));
    for (int i = 0; i < IDX_W; i++) begin
      ilv[2*i]   = last.lx.quo[i];
      ilv[2*i+1] = last.ly.quo[i];
    end
    r_item.key_valid = ok;
    r_item.tile_key  = ok ? KEY_W'({last.level, ilv}) : '0;
    r_item.tile_row  = ok ? last.ly.quo : '0;
    r_item.tile_col  = ok ? last.lx.quo : '0;
  end
endmodule
`default_nettype wire

// File: sv/point_to_tile_key_core.sv
// point_to_tile_key_core: maps a fixed point location and level to a tile key
// depends on ptk_pkg, ptk_front, ptk_back, ptk_fifo
//
// usage
// - input side is a queue: drive point_x, point_y, pyramid_level and push;
//   an item is taken at a clock edge with push high and full low
// - result side is a queue: while empty is low the oldest result sits on
//   tile_key, key_valid, tile_row, tile_col; pop with empty low takes it
// - cfg_wen/cfg_index/cfg_wdata write origin_x, origin_y, span_x, span_y;
//   write only while no item is in flight
// - one item per cycle sustained while the result side keeps up; a push passes
//   one front register, the work queue, 80 divider stages (one quotient
//   bit per stage and lane) and the result queue before empty falls
// - synchronous rst empties both queues and the divider pipe and loads the
//   default grid registers
// - when pop stays low the result queue fills, the divider pipe stops, the
//   work queue fills and then full rises; nothing is dropped
`default_nettype none
module point_to_tile_key_core import ptk_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic signed [COORD_W-1:0] point_x,
  input  wire logic signed [COORD_W-1:0] point_y,
  input  wire logic [5:0]                pyramid_level,
  input  wire logic                      pop,
  output logic                           empty,
  output logic [KEY_W-1:0]               tile_key,
  output logic                           key_valid,
  output logic [IDX_W-1:0]               tile_row,
  output logic [IDX_W-1:0]               tile_col,
  input  wire logic                      cfg_wen,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [COORD_W-1:0]        cfg_wdata
);
  // grid registers
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic [SPAN_W-1:0]         span_x;
  logic [SPAN_W-1:0]         span_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= -48'sd3019898880;
      origin_y <= 48'sd1509949440;
      span_x   <= 47'd6039797760;
      span_y   <= 47'd6039797760;
    end else if (cfg_wen) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X: origin_x <= cfg_wdata;
        REG_ORIGIN_Y: origin_y <= cfg_wdata;
        REG_SPAN_X:   span_x   <= cfg_wdata[SPAN_W-1:0];
        REG_SPAN_Y:   span_y   <= cfg_wdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // front: offsets and shifted magnitudes
  logic  f_push;
  work_t f_item;
  logic  wq_full;
  logic  wq_empty;
  logic  wq_pop;
  work_t wq_item;

  ptk_front u_front (
    .clk, .rst, .push, .full, .point_x, .point_y, .pyramid_level,
    .origin_x, .origin_y,
    .q_push(f_push), .q_item(f_item), .q_full(wq_full)
  );

  // decoupling queue between front and dividers
  ptk_fifo #(.WIDTH($bits(work_t)), .DEPTH(4)) u_work_q (
    .clk, .rst,
    .push(f_push), .wdata(f_item), .full(wq_full),
    .pop(wq_pop), .rdata(wq_item), .empty(wq_empty)
  );

  // back: divider pipe and key packing
  logic    b_push;
  result_t b_item;
  logic    rq_full;
  result_t rq_item;

  ptk_back u_back (
    .clk, .rst,
    .q_empty(wq_empty), .q_item(wq_item), .q_pop(wq_pop),
    .span_x, .span_y,
    .r_push(b_push), .r_item(b_item), .r_full(rq_full)
  );

  // result queue, holds finished items while the receiver stalls
  ptk_fifo #(.WIDTH($bits(result_t)), .DEPTH(4)) u_result_q (
    .clk, .rst,
    .push(b_push), .wdata(b_item), .full(rq_full),
    .pop, .rdata(rq_item), .empty
  );

  assign tile_key  = rq_item.tile_key;
  assign key_valid = rq_item.key_valid;
  assign tile_row  = rq_item.tile_row;
  assign tile_col  = rq_item.tile_col;
endmodule
`default_nettype wire

// File: sv/ptk_checker.sv
// ptk_checker: port level checks for point_to_tile_key_core, with bind
// depends on ptk_pkg and point_to_tile_key_core
`default_nettype none
module ptk_checker import ptk_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             empty,
  input wire logic             pop,
  input wire logic [KEY_W-1:0] tile_key,
  input wire logic             key_valid,
  input wire logic [IDX_W-1:0] tile_row,
  input wire logic [IDX_W-1:0] tile_col
);
  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result present after reset");

  // an invalid item carries all zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !key_valid) |-> (tile_key == '0 && tile_row == '0 && tile_col == '0))
    else $error("invalid item with nonzero fields");

  // low key bits interleave col and row
  a_interleave: assert property (@(posedge clk) disable iff (rst)
    (!empty && key_valid) |-> (tile_key[0] == tile_col[0] && tile_key[1] == tile_row[0]
      && tile_key[2*IDX_W-2] == tile_col[IDX_W-1] && tile_key[2*IDX_W-1] == tile_row[IDX_W-1]))
    else $error("key does not interleave row and col");

  // a waiting result holds while not popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(tile_key) && $stable(key_valid)))
    else $error("waiting result changed");
endmodule

bind point_to_tile_key_core ptk_checker u_ptk_checker (
  .clk, .rst, .empty, .pop, .tile_key, .key_valid, .tile_row, .tile_col
);
`default_nettype wire

// File: sim/point_to_tile_key_core_tb.sv
// point_to_tile_key_core_tb: self-checking regression for the point to tile key core
// depends on ptk_pkg and point_to_tile_key_core; predicts every key with its own divider model
`timescale 1ns / 100ps
`default_nettype none

// keeps the grid registers and the queue of keys still owed by the core
class tile_key_board;
  logic signed [47:0] org_x, org_y;
  logic [46:0]        step_x, step_y;
  ptk_pkg::result_t   owed_keys[$];
  int                 fails;

  function new();
    org_x  = -48'sd3019898880;
    org_y  = 48'sd1509949440;
    step_x = 47'd6039797760;
    step_y = 47'd6039797760;
    fails  = 0;
  endfunction

  // one axis: signed offset, scaled by the level, divided by the tile size
  function automatic bit axis_index(logic signed [63:0] offs, logic [46:0] size, int lvl,
                                    output logic [25:0] idx);
    logic [127:0] mag;
    logic [127:0] quo;
    bit           neg;
    neg = offs < 0;
    mag = neg ? 128'(-offs) : 128'(offs);
    mag = mag & ((128'd1 << 49) - 1);
    idx = '0;
    if (size == 0) return 0;         // zero tile size overflows the divider
    quo = (mag << lvl) / 128'(size);
    if ((quo >> 26) != 0) return 0;  // index beyond the grid
    if (neg && quo != 0) return 0;   // left of or above the origin
    idx = quo[25:0];
    return 1;
  endfunction

  function void note_point(logic signed [47:0] px, logic signed [47:0] py, logic [5:0] lvl);
    ptk_pkg::result_t   r;
    logic signed [63:0] dx, dy;
    logic [25:0]        col, row;
    bit                 ok;
    dx = $signed(px) - $signed(org_x);
    dy = $signed(org_y) - $signed(py);
    ok = lvl <= 6'd31;
    if (ok) ok = axis_index(dx, step_x, lvl, col);
    if (ok) ok = axis_index(dy, step_y, lvl, row);
    r = '0;
    if (ok) begin
      r.key_valid = 1'b1;
      r.tile_row  = row;
      r.tile_col  = col;
      r.tile_key  = 57'(lvl) << 52;
      for (int i = 0; i < 26; i++) begin
        r.tile_key[2*i]   = col[i];
        r.tile_key[2*i+1] = row[i];
      end
    end
    owed_keys.insert(owed_keys.size(), r);
  endfunction

  function void check_key(ptk_pkg::result_t got);
    ptk_pkg::result_t want;
    if (owed_keys.size() == 0) begin
      $error("result with no item outstanding: key %h", got.tile_key);
      fails++;
      return;
    end
    want = owed_keys.pop_front();
    if (got.tile_key !== want.tile_key) begin
      $error("tile_key expected %h actual %h", want.tile_key, got.tile_key);
      fails++;
    end
    if (got.key_valid !== want.key_valid) begin
      $error("key_valid expected %b actual %b", want.key_valid, got.key_valid);
      fails++;
    end
    if (got.tile_row !== want.tile_row) begin
      $error("tile_row expected %h actual %h", want.tile_row, got.tile_row);
      fails++;
    end
    if (got.tile_col !== want.tile_col) begin
      $error("tile_col expected %h actual %h", want.tile_col, got.tile_col);
      fails++;
    end
  endfunction
endclass

module point_to_tile_key_core_tb;
  import ptk_pkg::*;

  localparam int STALL_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int DRAIN_WAIT  = 120;   // extra settle time after the last owed key is back

  logic               clk;
  logic               rst;
  logic               push, full, pop, empty;
  logic signed [47:0] point_x, point_y;
  logic [5:0]         pyramid_level;
  logic [KEY_W-1:0]   tile_key;
  logic               key_valid;
  logic [IDX_W-1:0]   tile_row, tile_col;
  logic               cfg_wen;
  reg_idx_t           cfg_index;
  logic [47:0]        cfg_wdata;

  tile_key_board board = new();
  int                idle_mode;  // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  int                quiet_cycles;

  point_to_tile_key_core u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .point_x(point_x), .point_y(point_y), .pyramid_level(pyramid_level),
    .pop(pop), .empty(empty), .tile_key(tile_key), .key_valid(key_valid),
    .tile_row(tile_row), .tile_col(tile_col),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic int idle_pct(bit sender);
    case (idle_mode)
      1: return sender ? 58 : 0;
      2: return sender ? 0 : 58;
      3: return 17;
      default: return 0;
    endcase
  endfunction

  // receiver side: pop stalls at random per the current idling mode
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= idle_pct(0));
    end
  end

  // monitor: both handshakes sampled at the edge, before any new drive lands
  always @(posedge clk) begin
    if (!rst && push && !full) board.note_point(point_x, point_y, pyramid_level);
    if (!rst && pop && !empty) begin
      board.check_key('{tile_key: tile_key, key_valid: key_valid,
                        tile_row: tile_row, tile_col: tile_col});
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("point_to_tile_key_core regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  // offers one item and holds it until the core takes it
  task automatic send_point(logic signed [47:0] px, logic signed [47:0] py, logic [5:0] lvl);
    if ($urandom_range(99) < idle_pct(1)) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct(1)) @(posedge clk);
    end
    push          <= 1'b1;
    point_x       <= px;
    point_y       <= py;
    pyramid_level <= lvl;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [47:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_ORIGIN_X: board.org_x  = val;
      REG_ORIGIN_Y: board.org_y  = val;
      REG_SPAN_X:   board.step_x = val[46:0];
      default:      board.step_y = val[46:0];
    endcase
  endtask

  // waits until every owed key is back and the pipe has settled
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (board.owed_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic load_grid(logic [47:0] ox, logic [47:0] oy, logic [47:0] sx, logic [47:0] sy);
    drain();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_SPAN_X, sx);
    write_reg(REG_SPAN_Y, sy);
  endtask

  // mostly points inside the level-zero tile, some just outside, some raw noise
  task automatic random_points(int count);
    logic [63:0]        ox, oy;
    logic signed [47:0] px, py;
    logic [5:0]         lvl;
    int                 kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      lvl  = ($urandom_range(99) < 88) ? 6'($urandom_range(31)) : 6'($urandom_range(63, 32));
      if (kind < 70) begin
        ox = board.step_x ? ({$urandom, $urandom} % board.step_x) : 64'(rand48());
        oy = board.step_y ? ({$urandom, $urandom} % board.step_y) : 64'(rand48());
        px = board.org_x + 48'(ox);
        py = board.org_y - 48'(oy);
      end else if (kind < 82) begin
        // small offsets of either sign around the origin
        px = board.org_x + 48'($signed(12'($urandom)));
        py = board.org_y - 48'($signed(12'($urandom)));
      end else begin
        px = rand48();
        py = rand48();
      end
      send_point(px, py, lvl);
    end
  endtask

  initial begin
    rst           <= 1'b1;
    push          <= 1'b0;
    point_x       <= '0;
    point_y       <= '0;
    pyramid_level <= '0;
    cfg_wen       <= 1'b0;
    cfg_index     <= REG_ORIGIN_X;
    cfg_wdata     <= '0;
    idle_mode     = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: default grid, origin at -180 by 90 degrees, tiles 360 degrees on a side
    send_point(48'sd0, 48'sd0, 6'd0);
    send_point(48'sd0, 48'sd0, 6'd31);
    send_point(48'sd0, 48'sd0, 6'd32);                 // level too high
    send_point(48'sd0, 48'sd0, 6'd63);
    send_point(-48'sd3019898880, 48'sd1509949440, 6'd5); // exact origin corner
    send_point(-48'sd3019898881, 48'sd0, 6'd0);          // tiny negative offset stays 0
    send_point(-48'sd3019898881, 48'sd0, 6'd31);         // shifted: col still 0, row index too large
    send_point(48'sd0, 48'sd1509949441, 6'd10);
    send_point(48'sd3019898879, -48'sd1509949440, 6'd31);
    send_point(48'sd3019898880, 48'sd0, 6'd0);           // right edge: index 1 at level 0
    send_point(48'sh7fffffffffff, 48'sh800000000000, 6'd0);
    send_point(48'sh7fffffffffff, 48'sh800000000000, 6'd31); // index too large
    send_point(48'sh800000000000, 48'sh7fffffffffff, 6'd1);
    send_point(48'sh555555555555, 48'shaaaaaaaaaaaa, 6'd21);
    send_point(48'shaaaaaaaaaaaa, 48'sh555555555555, 6'd42);
    send_point(48'sd1000000000, -48'sd700000000, 6'd25);
    send_point(48'sd1000000000, -48'sd700000000, 6'd26);
    random_points(160);

    // extreme origins, widest tiles
    idle_mode = 1;
    load_grid(48'h800000000000, 48'h7fffffffffff, 48'h7fffffffffff, 48'h7fffffffffff);
    send_point(48'sh7fffffffffff, 48'sh800000000000, 6'd31);
    send_point(48'sh7fffffffffff, 48'sh800000000000, 6'd25);
    random_points(170);

    // unit tiles: the index overflows almost at once
    idle_mode = 2;
    load_grid(48'h0, 48'h0, 48'h1, 48'h1);
    send_point(48'sd67108863, -48'sd67108863, 6'd0);
    send_point(48'sd67108864, 48'sd0, 6'd0);
    send_point(-48'sd1, 48'sd1, 6'd0);
    random_points(170);

    // zero tile width makes every column invalid
    idle_mode = 3;
    load_grid(rand48(), rand48(), 48'h0, 48'(1 + $urandom_range(1 << 20)));
    random_points(120);

    // random grids with a spread of tile sizes
    for (int ph = 0; ph < 3; ph++) begin
      idle_mode = ph;
      load_grid(rand48(), rand48(), (rand48() & 48'h7fffffffffff) >> $urandom_range(46),
                (rand48() & 48'h7fffffffffff) >> $urandom_range(46));
      random_points(136);
    end

    drain();
    if (board.fails == 0 && board.owed_keys.size() == 0) begin
      $display("point_to_tile_key_core regression: pass");
    end else begin
      $display("point_to_tile_key_core regression: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
